// ===== src/hss_pkg.sv =====
// Shared types and constants for the Hermite spline sampler.
// No dependencies; the sampler, controller and datapath files import this package.
package hss_pkg;

	localparam int AXES     = 3;
	localparam int WIN      = 3;
	localparam int Q14_ONE  = 16384;
	// signed width that holds one plus or minus a 16-bit Q1.14 register
	localparam int BW       = 18;
	localparam int REG_W    = 16;
	localparam int STEPS_W  = 7;
	localparam int IDX_W    = 2;

	localparam logic [IDX_W-1:0] REG_TENSION = 2'd0;
	localparam logic [IDX_W-1:0] REG_BIAS    = 2'd1;
	localparam logic [IDX_W-1:0] REG_STEPS   = 2'd2;

	// controller to datapath commands
	typedef struct packed {
		logic accept;
		logic tan_a;
		logic tan_b;
		logic tan_c;
		logic k_a;
		logic k_b;
		logic coef;
		logic mul;
		logic sum;
		logic prep;
		logic div_step;
		logic fin;
		logic next_k;
	} hss_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic compute;
		logic last;
	} hss_sts_t;

endpackage

// ===== src/hss_ifs.sv =====
// Stream interfaces for control points in and samples out.
// Depends on nothing; width follows the coordinate parameter.
interface hss_point_if #(parameter int CW = 16);
	logic                 valid;
	logic                 ready;
	logic signed [CW-1:0] point_x;
	logic signed [CW-1:0] point_y;
	logic signed [CW-1:0] point_z;
	logic                 new_curve;
	modport source (output valid, point_x, point_y, point_z, new_curve, input ready);
	modport sink   (input valid, point_x, point_y, point_z, new_curve, output ready);
endinterface

interface hss_sample_if #(parameter int CW = 16);
	logic                 valid;
	logic                 ready;
	logic signed [CW-1:0] sample_x;
	logic signed [CW-1:0] sample_y;
	logic signed [CW-1:0] sample_z;
	logic                 last_of_segment;
	modport source (output valid, sample_x, sample_y, sample_z, last_of_segment, input ready);
	modport sink   (input valid, sample_x, sample_y, sample_z, last_of_segment, output ready);
endinterface

// ===== src/hermite_spline_sampler.sv =====
// A point that completes a segment starts the sequence: tangent states TAN_A,
// TAN_B and TAN_C, then per sample K_A, K_B, COEF, MUL, SUM, PREP, the serial
// divide in DIV, and FIN, which raises the sample valid. Each further sample
// starts only after the previous sample transfer, so output stalls hold it.
// Input is taken only between segments, while the controller is idle.
// Reset clears the window, point count, controller and registers to defaults.
module hermite_spline_sampler #(
	parameter int COORD_WIDTH = 16,
	parameter int MAX_STEPS   = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	hss_point_if.sink                   point,
	hss_sample_if.source                sample,
	input  logic                        cfg_we,
	input  logic [hss_pkg::IDX_W-1:0]   cfg_index,
	input  logic [hss_pkg::REG_W-1:0]   cfg_wdata
);
	import hss_pkg::*;

	logic [REG_W-1:0]   tension_q;
	logic [REG_W-1:0]   bias_q;
	logic [STEPS_W-1:0] steps_q;
	hss_cmd_t           cmd;
	hss_sts_t           sts;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tension_q <= '0;
			bias_q    <= '0;
			steps_q   <= STEPS_W'(64);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TENSION: tension_q <= cfg_wdata;
				REG_BIAS:    bias_q    <= cfg_wdata;
				REG_STEPS:   steps_q   <= cfg_wdata[STEPS_W-1:0];
				default: ;
			endcase
		end
	end

	hss_ctrl #(.CW(COORD_WIDTH)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (point.valid),
		.in_ready  (point.ready),
		.out_valid (sample.valid),
		.out_ready (sample.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	hss_dp #(.CW(COORD_WIDTH), .MAX_STEPS(MAX_STEPS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.pt_x      (point.point_x),
		.pt_y      (point.point_y),
		.pt_z      (point.point_z),
		.new_curve (point.new_curve),
		.tension   (tension_q),
		.bias      (bias_q),
		.steps     (steps_q),
		.smp_x     (sample.sample_x),
		.smp_y     (sample.sample_y),
		.smp_z     (sample.sample_z),
		.smp_last  (sample.last_of_segment)
	);

	// no point taken while a sample is pending
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		point.ready |-> !sample.valid)
		else $error("point accepted while sample pending");

	// the last sample of a segment frees the input
	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(sample.valid && sample.ready && sample.last_of_segment) |=> point.ready)
		else $error("input not ready after last sample");

endmodule

// ===== src/hss_ctrl.sv =====
// Sequencer for the sampler: tangent setup, per-sample coefficient,
// multiply and divide phases, output handshake. Depends on hss_pkg.
module hss_ctrl #(
	parameter int CW = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  hss_pkg::hss_sts_t sts,
	output hss_pkg::hss_cmd_t cmd
);
	import hss_pkg::*;

	localparam int CNTW = $clog2(CW);

	typedef enum logic [3:0] {
		ST_IDLE, ST_TAN_A, ST_TAN_B, ST_TAN_C, ST_K_A, ST_K_B, ST_COEF,
		ST_MUL, ST_SUM, ST_PREP, ST_DIV, ST_FIN, ST_OUT
	} state_t;

	state_t            state_q;
	logic [CNTW-1:0]   cnt_q;
	logic              in_xfer;
	logic              out_xfer;

	assign in_ready = (state_q == ST_IDLE);
	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid && out_ready;

	// commands decoded from state and from the input and output handshakes
	always_comb begin
		cmd          = '0;
		cmd.accept   = in_xfer;
		cmd.tan_a    = (state_q == ST_TAN_A);
		cmd.tan_b    = (state_q == ST_TAN_B);
		cmd.tan_c    = (state_q == ST_TAN_C);
		cmd.k_a      = (state_q == ST_K_A);
		cmd.k_b      = (state_q == ST_K_B);
		cmd.coef     = (state_q == ST_COEF);
		cmd.mul      = (state_q == ST_MUL);
		cmd.sum      = (state_q == ST_SUM);
		cmd.prep     = (state_q == ST_PREP);
		cmd.div_step = (state_q == ST_DIV);
		cmd.fin      = (state_q == ST_FIN);
		cmd.next_k   = out_xfer && !sts.last;
	end

	// state, division count and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer && sts.compute) state_q <= ST_TAN_A;
				end
				ST_TAN_A: state_q <= ST_TAN_B;
				ST_TAN_B: state_q <= ST_TAN_C;
				ST_TAN_C: state_q <= ST_K_A;
				ST_K_A:   state_q <= ST_K_B;
				ST_K_B:   state_q <= ST_COEF;
				ST_COEF:  state_q <= ST_MUL;
				ST_MUL:   state_q <= ST_SUM;
				ST_SUM:   state_q <= ST_PREP;
				ST_PREP: begin
					cnt_q   <= CNTW'(CW - 1);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (cnt_q == '0) state_q <= ST_FIN;
					else cnt_q <= cnt_q - 1'b1;
				end
				ST_FIN: begin
					out_valid <= 1'b1;
					state_q   <= ST_OUT;
				end
				ST_OUT: begin
					if (out_xfer) begin
						out_valid <= 1'b0;
						state_q   <= sts.last ? ST_IDLE : ST_K_A;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== src/hss_dp.sv =====
// Datapath: point window, tangents, basis coefficients, per-axis products
// and restoring dividers with saturation. Depends on hss_pkg.
module hss_dp #(
	parameter int CW        = 16,
	parameter int MAX_STEPS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  hss_pkg::hss_cmd_t             cmd,
	output hss_pkg::hss_sts_t             sts,
	input  logic signed [CW-1:0]          pt_x,
	input  logic signed [CW-1:0]          pt_y,
	input  logic signed [CW-1:0]          pt_z,
	input  logic                          new_curve,
	input  logic [hss_pkg::REG_W-1:0]     tension,
	input  logic [hss_pkg::REG_W-1:0]     bias,
	input  logic [hss_pkg::STEPS_W-1:0]   steps,
	output logic signed [CW-1:0]          smp_x,
	output logic signed [CW-1:0]          smp_y,
	output logic signed [CW-1:0]          smp_z,
	output logic                          smp_last
);
	import hss_pkg::*;

	localparam int NW    = $clog2(MAX_STEPS + 1);
	localparam int N2W   = 2 * NW;
	localparam int N3W   = 3 * NW;
	localparam int DW    = CW + 1;
	localparam int SUMW  = DW + BW + 1;
	localparam int PW    = SUMW - 7;
	localparam int TPW   = PW + BW;
	localparam int MW    = TPW - 14;
	localparam int CFW   = N3W + 3;
	localparam int PRPW  = CFW + CW;
	localparam int PRMW  = CFW + MW;
	localparam int NUMW  = ((PRPW + 9 > PRMW + 2) ? PRPW + 9 : PRMW + 2) + 1;
	localparam int AW    = NUMW + 1;
	localparam int DVW   = N3W + 8;
	localparam int SDW   = DVW + CW;
	localparam int CMPW  = (AW > SDW + 1) ? AW : SDW + 1;

	// window and held count
	logic signed [CW-1:0]   win_q  [WIN][AXES];
	logic [1:0]             held_q;
	logic signed [CW-1:0]   pt     [AXES];

	// segment setup
	logic signed [CW-1:0]   p1_q   [AXES];
	logic signed [CW-1:0]   p2_q   [AXES];
	logic signed [DW-1:0]   da_q   [2][AXES];
	logic signed [DW-1:0]   db_q   [2][AXES];
	logic signed [SUMW-1:0] sum_q  [2][AXES];
	logic signed [TPW-1:0]  tp_q   [2][AXES];
	logic signed [MW-1:0]   m_q    [2][AXES];
	logic [NW-1:0]          neff_q;
	logic [N2W-1:0]         n2_q;
	logic [N3W-1:0]         n3_q;

	// per-sample
	logic [NW-1:0]          k_q;
	logic [N2W-1:0]         kk_q;
	logic [N3W-1:0]         kn2_q;
	logic [N3W-1:0]         k3_q;
	logic [N3W-1:0]         k2n_q;
	logic signed [CFW-1:0]  c0_q, c1_q, c2_q, c3_q;
	logic signed [PRPW-1:0] pr0_q  [AXES];
	logic signed [PRPW-1:0] pr3_q  [AXES];
	logic signed [PRMW-1:0] pr1_q  [AXES];
	logic signed [PRMW-1:0] pr2_q  [AXES];
	logic signed [NUMW-1:0] b_q    [AXES];
	logic [AW-1:0]          r_q    [AXES];
	logic [SDW-1:0]         dv_q;
	logic [CW-1:0]          q_q    [AXES];
	logic                   neg_q  [AXES];
	logic                   ovf_q  [AXES];

	logic signed [BW-1:0]   sb, sm, st;
	logic [DVW-1:0]         dvsr;
	logic [NW-1:0]          neff_n;

	assign pt[0] = pt_x;
	assign pt[1] = pt_y;
	assign pt[2] = pt_z;

	assign sb   = $signed(BW'(Q14_ONE)) + BW'($signed(bias));
	assign sm   = $signed(BW'(Q14_ONE)) - BW'($signed(bias));
	assign st   = $signed(BW'(Q14_ONE)) - BW'($signed(tension));
	assign dvsr = {n3_q, 8'b0};

	assign sts.compute = !new_curve && (held_q == 2'd3);
	assign sts.last    = (k_q == neff_q);

	// step count clamped to 1..MAX_STEPS
	always_comb begin
		if (steps == '0)                        neff_n = NW'(1);
		else if (steps > STEPS_W'(MAX_STEPS))   neff_n = NW'(MAX_STEPS);
		else                                    neff_n = NW'(steps);
	end

	// window and held count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			for (int i = 0; i < WIN; i++)
				for (int a = 0; a < AXES; a++)
					win_q[i][a] <= '0;
		end else if (cmd.accept) begin
			if (sts.compute) begin
				for (int a = 0; a < AXES; a++) begin
					win_q[0][a] <= win_q[1][a];
					win_q[1][a] <= win_q[2][a];
					win_q[2][a] <= pt[a];
				end
			end else if (new_curve) begin
				for (int i = 0; i < WIN; i++)
					for (int a = 0; a < AXES; a++)
						win_q[i][a] <= '0;
				for (int a = 0; a < AXES; a++)
					win_q[0][a] <= pt[a];
				held_q <= 2'd1;
			end else begin
				for (int a = 0; a < AXES; a++)
					win_q[held_q][a] <= pt[a];
				held_q <= held_q + 2'd1;
			end
		end
	end

	// segment setup: differences, tangents, n powers
	always_ff @(posedge clk) begin
		if (cmd.accept && sts.compute) begin
			neff_q <= neff_n;
			for (int a = 0; a < AXES; a++) begin
				p1_q[a]    <= win_q[1][a];
				p2_q[a]    <= win_q[2][a];
				da_q[0][a] <= DW'(win_q[1][a]) - DW'(win_q[0][a]);
				db_q[0][a] <= DW'(win_q[2][a]) - DW'(win_q[1][a]);
				da_q[1][a] <= DW'(win_q[2][a]) - DW'(win_q[1][a]);
				db_q[1][a] <= DW'(pt[a]) - DW'(win_q[2][a]);
			end
		end
		if (cmd.tan_a) begin
			n2_q <= N2W'(neff_q) * N2W'(neff_q);
			for (int j = 0; j < 2; j++)
				for (int a = 0; a < AXES; a++)
					sum_q[j][a] <= SUMW'(da_q[j][a] * sb) + SUMW'(db_q[j][a] * sm);
		end
		if (cmd.tan_b) begin
			n3_q <= N3W'(n2_q) * N3W'(neff_q);
			for (int j = 0; j < 2; j++)
				for (int a = 0; a < AXES; a++)
					tp_q[j][a] <= TPW'(PW'((sum_q[j][a] + $signed(SUMW'(64))) >>> 7)) * st;
		end
		if (cmd.tan_c) begin
			for (int j = 0; j < 2; j++)
				for (int a = 0; a < AXES; a++)
					m_q[j][a] <= MW'((tp_q[j][a] + $signed(TPW'(8192))) >>> 14);
		end
	end

	// sample index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)          k_q <= '0;
		else if (cmd.tan_c)   k_q <= NW'(1);
		else if (cmd.next_k)  k_q <= k_q + 1'b1;
	end

	// coefficients, products, divide setup with overflow flags, and divide steps
	always_ff @(posedge clk) begin
		if (cmd.k_a) begin
			kk_q  <= N2W'(k_q) * N2W'(k_q);
			kn2_q <= N3W'(k_q) * N3W'(n2_q);
		end
		if (cmd.k_b) begin
			k3_q  <= N3W'(kk_q) * N3W'(k_q);
			k2n_q <= N3W'(kk_q) * N3W'(neff_q);
		end
		if (cmd.coef) begin
			c0_q <= $signed(CFW'(k3_q)) + $signed(CFW'(k3_q))
			      - ($signed(CFW'(k2n_q)) + $signed(CFW'(k2n_q)) + $signed(CFW'(k2n_q)))
			      + $signed(CFW'(n3_q));
			c1_q <= $signed(CFW'(k3_q)) - ($signed(CFW'(k2n_q)) + $signed(CFW'(k2n_q)))
			      + $signed(CFW'(kn2_q));
			c2_q <= $signed(CFW'(k3_q)) - $signed(CFW'(k2n_q));
			c3_q <= $signed(CFW'(k2n_q)) + $signed(CFW'(k2n_q)) + $signed(CFW'(k2n_q))
			      - ($signed(CFW'(k3_q)) + $signed(CFW'(k3_q)));
		end
		if (cmd.mul) begin
			for (int a = 0; a < AXES; a++) begin
				pr0_q[a] <= PRPW'(c0_q) * PRPW'(p1_q[a]);
				pr3_q[a] <= PRPW'(c3_q) * PRPW'(p2_q[a]);
				pr1_q[a] <= PRMW'(c1_q) * PRMW'(m_q[0][a]);
				pr2_q[a] <= PRMW'(c2_q) * PRMW'(m_q[1][a]);
			end
		end
		if (cmd.sum) begin
			for (int a = 0; a < AXES; a++)
				b_q[a] <= ((NUMW'(pr0_q[a]) + NUMW'(pr3_q[a])) <<< 8)
				        + NUMW'(pr1_q[a]) + NUMW'(pr2_q[a])
				        + $signed(NUMW'({n3_q, 7'b0}));
		end
		// floor(b/D): magnitude, plus D-1 when negative gives the ceiling
		if (cmd.prep) begin
			dv_q <= SDW'(dvsr) << (CW - 1);
			for (int a = 0; a < AXES; a++) begin
				logic [AW-1:0] mag;
				logic [AW-1:0] abp;
				mag = b_q[a][NUMW-1] ? AW'(-b_q[a]) : AW'(b_q[a]);
				abp = b_q[a][NUMW-1] ? mag + AW'(dvsr) - AW'(1) : mag;
				neg_q[a] <= b_q[a][NUMW-1];
				ovf_q[a] <= CMPW'(abp) >= (CMPW'(dvsr) << CW);
				r_q[a]   <= abp;
				q_q[a]   <= '0;
			end
		end
		if (cmd.div_step) begin
			dv_q <= dv_q >> 1;
			for (int a = 0; a < AXES; a++) begin
				if (CMPW'(r_q[a]) >= CMPW'(dv_q)) begin
					r_q[a] <= r_q[a] - AW'(dv_q);
					q_q[a] <= {q_q[a][CW-2:0], 1'b1};
				end else begin
					q_q[a] <= {q_q[a][CW-2:0], 1'b0};
				end
			end
		end
	end

	// saturated result register
	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			logic signed [CW-1:0] res [AXES];
			for (int a = 0; a < AXES; a++) begin
				if (!neg_q[a]) begin
					if (ovf_q[a] || q_q[a][CW-1]) res[a] = {1'b0, {(CW-1){1'b1}}};
					else                          res[a] = $signed(q_q[a]);
				end else begin
					if (ovf_q[a] || (q_q[a][CW-1] && (|q_q[a][CW-2:0])))
						res[a] = {1'b1, {(CW-1){1'b0}}};
					else
						res[a] = $signed(-q_q[a]);
				end
			end
			smp_x    <= res[0];
			smp_y    <= res[1];
			smp_z    <= res[2];
			smp_last <= (k_q == neff_q);
		end
	end

endmodule
